### rtl/epd_pkg.sv
// Shared types and constants for the escaped packet deframer.
// No dependencies; every other file refers to this package by scoped names.
package epd_pkg;

  // Payload widths
  localparam int ByteW    = 8;
  localparam int KindW    = 3;
  localparam int DataIdxW = 6;
  localparam int ErrW     = 3;
  localparam int CfgIdxW  = 2;
  localparam int PhaseW   = 3;

  // Longest data section that is accepted without a length error
  localparam logic [ByteW-1:0] MAX_DATA_LEN = 8'd64;

  // Register defaults
  localparam logic [ByteW-1:0] START_BYTE_RST  = 8'd2;
  localparam logic [ByteW-1:0] END_BYTE_RST    = 8'd3;
  localparam logic [ByteW-1:0] ESCAPE_BYTE_RST = 8'd27;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_END    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE = 2'd2;

  // Result kinds
  localparam logic [KindW-1:0] KIND_CODE   = 3'd0;
  localparam logic [KindW-1:0] KIND_LEN    = 3'd1;
  localparam logic [KindW-1:0] KIND_DATA   = 3'd2;
  localparam logic [KindW-1:0] KIND_CRC    = 3'd3;
  localparam logic [KindW-1:0] KIND_STATUS = 3'd4;

  // Error codes
  localparam logic [ErrW-1:0] ERR_NONE        = 3'd0;
  localparam logic [ErrW-1:0] ERR_UNEXP_START = 3'd1;
  localparam logic [ErrW-1:0] ERR_UNEXP_END   = 3'd2;
  localparam logic [ErrW-1:0] ERR_LEN_LARGE   = 3'd3;
  localparam logic [ErrW-1:0] ERR_MISSING_END = 3'd4;

  // Framing control values
  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] end_byte;
    logic [ByteW-1:0] escape_byte;
  } cfg_t;

  // One decoded result
  typedef struct packed {
    logic [KindW-1:0]    field_kind;
    logic [ByteW-1:0]    field_value;
    logic [DataIdxW-1:0] data_index;
    logic                packet_ok;
    logic [ErrW-1:0]     error_code;
  } result_t;

endpackage

### rtl/epd_if.sv
// Channel interfaces of the escaped packet deframer: input bytes, results,
// configuration writes. Depends on epd_pkg for field widths.
interface epd_in_if;
  logic                         valid;
  logic                         ready;
  logic [epd_pkg::ByteW-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface epd_out_if;
  logic                         valid;
  logic                         ready;
  logic [epd_pkg::KindW-1:0]    field_kind;
  logic [epd_pkg::ByteW-1:0]    field_value;
  logic [epd_pkg::DataIdxW-1:0] data_index;
  logic                         packet_ok;
  logic [epd_pkg::ErrW-1:0]     error_code;

  modport source (output valid, output field_kind, output field_value,
                  output data_index, output packet_ok, output error_code,
                  input ready);
  modport sink   (input valid, input field_kind, input field_value,
                  input data_index, input packet_ok, input error_code,
                  output ready);
endinterface

interface epd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [epd_pkg::CfgIdxW-1:0]  reg_index;
  logic [epd_pkg::ByteW-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

### rtl/epd_cfg_regs.sv
// Framing control registers (start, end and escape byte values).
// Depends on epd_pkg and epd_cfg_if.
module epd_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  epd_cfg_if.sink           cfg_bus,
  output epd_pkg::cfg_t     cfg_o
);

  epd_pkg::cfg_t cfg_r;
  epd_pkg::cfg_t cfg_nxt;

  // Always take a write beat
  assign cfg_bus.ready = 1'b1;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      unique case (cfg_bus.reg_index)
        epd_pkg::CFG_START:  cfg_nxt.start_byte  = cfg_bus.wdata;
        epd_pkg::CFG_END:    cfg_nxt.end_byte    = cfg_bus.wdata;
        epd_pkg::CFG_ESCAPE: cfg_nxt.escape_byte = cfg_bus.wdata;
        default:             cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= epd_pkg::START_BYTE_RST;
      cfg_r.end_byte    <= epd_pkg::END_BYTE_RST;
      cfg_r.escape_byte <= epd_pkg::ESCAPE_BYTE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

### rtl/epd_decoder.sv
// Input byte register and framing state machine: one byte decoded per beat.
// Depends on epd_pkg and epd_in_if.
module epd_decoder #(
  parameter logic [epd_pkg::ByteW-1:0] MAX_DATA_LEN = epd_pkg::MAX_DATA_LEN
) (
  input  logic              clk,
  input  logic              rst_n,
  epd_in_if.sink            in_bus,
  input  epd_pkg::cfg_t     cfg_i,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  output epd_pkg::result_t  res_o
);

  localparam logic [epd_pkg::PhaseW-1:0] PH_HUNT = 3'd0;
  localparam logic [epd_pkg::PhaseW-1:0] PH_CODE = 3'd1;
  localparam logic [epd_pkg::PhaseW-1:0] PH_LEN  = 3'd2;
  localparam logic [epd_pkg::PhaseW-1:0] PH_DATA = 3'd3;
  localparam logic [epd_pkg::PhaseW-1:0] PH_CRC  = 3'd4;
  localparam logic [epd_pkg::PhaseW-1:0] PH_END  = 3'd5;

  logic                          byte_vld_r;
  logic [epd_pkg::ByteW-1:0]     byte_r;
  logic [epd_pkg::PhaseW-1:0]    phase_r, phase_nxt;
  logic                          esc_r, esc_nxt;
  logic [epd_pkg::ByteW-1:0]     len_r, len_nxt;
  logic [epd_pkg::ByteW-1:0]     cnt_r, cnt_nxt;
  logic [epd_pkg::ErrW-1:0]      ferr_r, ferr_nxt;
  logic                          res_vld;
  epd_pkg::result_t              res;
  logic                          fire;
  logic                          good_end;
  logic [epd_pkg::ByteW-1:0]     cnt_inc;
  logic [epd_pkg::ErrW-1:0]      err_or_start, err_or_end;

  // Retire the held byte when it makes no result or the output can take one
  assign fire         = byte_vld_r && (!res_vld || res_ready_i);
  assign in_bus.ready = !byte_vld_r || fire;

  assign good_end     = (byte_r == cfg_i.end_byte);
  assign cnt_inc      = cnt_r + 8'd1;
  assign err_or_start = (ferr_r != epd_pkg::ERR_NONE) ? ferr_r : epd_pkg::ERR_UNEXP_START;
  assign err_or_end   = (ferr_r != epd_pkg::ERR_NONE) ? ferr_r : epd_pkg::ERR_UNEXP_END;

  // Next state and result for the held byte
  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    ferr_nxt  = ferr_r;
    res_vld   = 1'b0;
    res       = '0;

    unique case (phase_r) inside
      PH_END: begin
        // Closing byte is taken raw
        res_vld          = 1'b1;
        res.field_kind   = epd_pkg::KIND_STATUS;
        res.packet_ok    = (ferr_r == epd_pkg::ERR_NONE) && good_end;
        res.error_code   = (ferr_r != epd_pkg::ERR_NONE) ? ferr_r :
                           (good_end ? epd_pkg::ERR_NONE : epd_pkg::ERR_MISSING_END);
        phase_nxt        = PH_HUNT;
        esc_nxt          = 1'b0;
      end
      PH_CODE, PH_LEN, PH_DATA, PH_CRC: begin
        if (!esc_r && byte_r == cfg_i.start_byte) begin
          // Abort and open a new packet
          res_vld        = 1'b1;
          res.field_kind = epd_pkg::KIND_STATUS;
          res.error_code = err_or_start;
          phase_nxt      = PH_CODE;
          esc_nxt        = 1'b0;
          len_nxt        = '0;
          cnt_nxt        = '0;
          ferr_nxt       = epd_pkg::ERR_NONE;
        end else if (!esc_r && byte_r == cfg_i.end_byte) begin
          // Abort and go back to hunting
          res_vld        = 1'b1;
          res.field_kind = epd_pkg::KIND_STATUS;
          res.error_code = err_or_end;
          phase_nxt      = PH_HUNT;
          esc_nxt        = 1'b0;
        end else if (!esc_r && byte_r == cfg_i.escape_byte) begin
          esc_nxt = 1'b1;
        end else begin
          esc_nxt         = 1'b0;
          res_vld         = 1'b1;
          res.field_value = byte_r;
          unique case (phase_r)
            PH_CODE: begin
              res.field_kind = epd_pkg::KIND_CODE;
              phase_nxt      = PH_LEN;
            end
            PH_LEN: begin
              res.field_kind = epd_pkg::KIND_LEN;
              len_nxt        = byte_r;
              cnt_nxt        = '0;
              if (byte_r > MAX_DATA_LEN && ferr_r == epd_pkg::ERR_NONE) begin
                ferr_nxt = epd_pkg::ERR_LEN_LARGE;
              end
              phase_nxt = (byte_r == '0) ? PH_CRC : PH_DATA;
            end
            PH_DATA: begin
              res.field_kind = epd_pkg::KIND_DATA;
              res.data_index = cnt_r[epd_pkg::DataIdxW-1:0];
              cnt_nxt        = cnt_inc;
              if (cnt_inc >= len_r) begin
                phase_nxt = PH_CRC;
              end
            end
            default: begin
              res.field_kind = epd_pkg::KIND_CRC;
              phase_nxt      = PH_END;
            end
          endcase
        end
      end
      default: begin
        // Hunt: drop everything but the start byte
        if (byte_r == cfg_i.start_byte) begin
          phase_nxt = PH_CODE;
          esc_nxt   = 1'b0;
          len_nxt   = '0;
          cnt_nxt   = '0;
          ferr_nxt  = epd_pkg::ERR_NONE;
        end else begin
          phase_nxt = PH_HUNT;
          esc_nxt   = 1'b0;
        end
      end
    endcase
  end

  // Input byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      byte_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      byte_r <= in_bus.rx_byte;
    end
  end

  // Advance the framing state on each retired byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      esc_r   <= 1'b0;
      len_r   <= '0;
      cnt_r   <= '0;
      ferr_r  <= epd_pkg::ERR_NONE;
    end else if (fire) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      ferr_r  <= ferr_nxt;
    end
  end

  assign res_valid_o = fire && res_vld;
  assign res_o       = res;

endmodule

### rtl/epd_out_stage.sv
// Result register that drives the output channel.
// Depends on epd_pkg and epd_out_if.
module epd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid_i,
  input  epd_pkg::result_t  res_i,
  output logic              res_ready_o,
  epd_out_if.source         out_bus
);

  logic             vld_r;
  epd_pkg::result_t res_r;

  // Take a new result when empty or when the held one leaves this cycle
  assign res_ready_o = !vld_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_ready_o) begin
      vld_r <= res_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready_o && res_valid_i) begin
      res_r <= res_i;
    end
  end

  assign out_bus.valid       = vld_r;
  assign out_bus.field_kind  = res_r.field_kind;
  assign out_bus.field_value = res_r.field_value;
  assign out_bus.data_index  = res_r.data_index;
  assign out_bus.packet_ok   = res_r.packet_ok;
  assign out_bus.error_code  = res_r.error_code;

endmodule

### rtl/escaped_packet_deframer.sv
// Top level of the escaped packet deframer: control registers, decoder,
// result register. Depends on epd_pkg, epd_if, epd_cfg_regs, epd_decoder, epd_out_stage.
//
//   channel   dir  payload                                           beat
//   in_bus    in   rx_byte                                           one received byte
//   out_bus   out  field_kind field_value data_index packet_ok        one decoded field
//                  error_code                                        or packet status
//   cfg_bus   in   reg_index wdata                                   one register write
//
// One byte per cycle sustained while out_bus is not stalled; a result passes
// the input register, then the result register, before it is on out_bus.
// Reset (rst_n low at a clock edge) restores the default framing bytes and
// returns the decoder to hunting for a start byte.
// An output stall holds the result register; the input register then holds
// the next byte that makes a result, and bytes that make no result keep flowing.
module escaped_packet_deframer #(
  parameter logic [epd_pkg::ByteW-1:0] MAX_DATA_LEN = epd_pkg::MAX_DATA_LEN
) (
  input  logic       clk,
  input  logic       rst_n,
  epd_in_if.sink     in_bus,
  epd_out_if.source  out_bus,
  epd_cfg_if.sink    cfg_bus
);

  epd_pkg::cfg_t    cfg;
  epd_pkg::result_t res;
  logic             res_valid;
  logic             res_ready;

  epd_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg_o   (cfg)
  );

  epd_decoder #(
    .MAX_DATA_LEN (MAX_DATA_LEN)
  ) u_decoder (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .cfg_i       (cfg),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  epd_out_stage u_out_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_bus     (out_bus)
  );

endmodule
